### src/stack_permutation_checker_core_assert.svh
// Assertion macros used by the checker module of this block.
`ifndef STACK_PERMUTATION_CHECKER_CORE_ASSERT_SVH
`define STACK_PERMUTATION_CHECKER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/spc_pkg.sv
package spc_pkg;

   localparam int MAX_ELEMENTS_DEF = 1024;
   localparam int ELEM_W           = 11;
   localparam int VERDICT_W        = 2;

   localparam logic [VERDICT_W-1:0] VERDICT_PENDING = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT  = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_REJECT  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic fetch;
      logic decide;
      logic push;
      logic finish;
   } cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic run_push;
      logic push_done;
      logic out_free;
   } status_type;

endpackage

### src/spc_controller.sv
module spc_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  spc_pkg::status_type  status,
   output spc_pkg::cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FETCH  = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_PUSH   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = status.run_push ? ST_PUSH : ST_FINISH;
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            if (status.push_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold here until the result register can take the beat.
            cmd.finish = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/spc_datapath.sv
module spc_datapath #(
   parameter int MAX_ELEMENTS = spc_pkg::MAX_ELEMENTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [spc_pkg::ELEM_W-1:0]    csr_wr_data,
   input  logic [spc_pkg::ELEM_W-1:0]    req_element,
   input  spc_pkg::cmd_type              cmd,
   output spc_pkg::status_type           status,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [spc_pkg::VERDICT_W-1:0] rsp_verdict,
   output logic                          rsp_last
);

   localparam int ELEM_W  = spc_pkg::ELEM_W;
   localparam int DEPTH_W = $clog2(MAX_ELEMENTS + 1);
   localparam int ADDR_W  = $clog2(MAX_ELEMENTS);
   localparam int NEXT_W  = ELEM_W + 1;
   localparam int CNT_W   = (DEPTH_W > NEXT_W) ? DEPTH_W : NEXT_W;

   logic [ELEM_W-1:0]  count_ff;
   logic [ELEM_W-1:0]  element_ff;
   logic [ELEM_W-1:0]  top_ff;
   logic [ELEM_W-1:0]  stack_mem [MAX_ELEMENTS];
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [NEXT_W-1:0]  next_ff, next_in;
   logic [ELEM_W-1:0]  pos_ff, pos_in;
   logic               failed_ff, failed_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [spc_pkg::VERDICT_W-1:0] rsp_verdict_ff;
   logic               rsp_last_ff;

   logic [CNT_W-1:0]   count_ext, n_eff, elem_ext, next_ext;
   logic [DEPTH_W-1:0] depth_m1;
   logic [ADDR_W-1:0]  rd_addr;
   logic [NEXT_W-1:0]  next_plus1;
   logic [ELEM_W:0]    pos_plus1;
   logic               out_of_range, hit_next, hit_top, below, stack_full, run_end;
   logic               order_closed, mem_we;
   logic [spc_pkg::VERDICT_W-1:0] verdict_in;

   // Effective order length: zero reads as one, and it saturates at capacity.
   always_comb begin
      count_ext = CNT_W'(count_ff);
      if (count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (count_ext > CNT_W'(MAX_ELEMENTS)) begin
         n_eff = CNT_W'(MAX_ELEMENTS);
      end else begin
         n_eff = count_ext;
      end
   end

   assign elem_ext     = CNT_W'(element_ff);
   assign next_ext     = CNT_W'(next_ff);
   assign out_of_range = (element_ff == '0) || (elem_ext > n_eff);
   assign hit_next     = (next_ext == elem_ext);
   assign hit_top      = (depth_ff != '0) && (top_ff == element_ff);
   assign below        = (next_ext < elem_ext);
   assign stack_full   = (depth_ff >= DEPTH_W'(MAX_ELEMENTS));
   assign next_plus1   = next_ff + NEXT_W'(1);
   assign run_end      = (CNT_W'(next_plus1) == elem_ext);
   assign depth_m1     = depth_ff - DEPTH_W'(1);
   assign rd_addr      = depth_m1[ADDR_W-1:0];
   assign pos_plus1    = {1'b0, pos_ff} + (ELEM_W + 1)'(1);
   assign order_closed = (CNT_W'(pos_plus1) >= n_eff);
   assign mem_we       = cmd.push && !stack_full;

   assign status.run_push  = !failed_ff && !out_of_range && !hit_next && !hit_top && below;
   assign status.push_done = stack_full || run_end;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      depth_in     = depth_ff;
      next_in      = next_ff;
      pos_in       = pos_ff;
      failed_in    = failed_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      verdict_in   = spc_pkg::VERDICT_PENDING;

      if (cmd.decide && !failed_ff) begin
         if (out_of_range) begin
            failed_in = 1'b1;
         end else if (hit_next) begin
            next_in = next_plus1;
         end else if (hit_top) begin
            depth_in = depth_m1;
         end else if (!below) begin
            failed_in = 1'b1;
         end
      end

      // One element of the run goes onto the stack per cycle; the element
      // that ends the run passes straight through.
      if (cmd.push) begin
         if (stack_full) begin
            failed_in = 1'b1;
         end else begin
            depth_in = depth_ff + DEPTH_W'(1);
            next_in  = run_end ? next_ff + NEXT_W'(2) : next_plus1;
         end
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         if (order_closed) begin
            verdict_in = (!failed_ff && depth_ff == '0) ? spc_pkg::VERDICT_ACCEPT
                                                        : spc_pkg::VERDICT_REJECT;
            depth_in   = '0;
            next_in    = NEXT_W'(1);
            pos_in     = '0;
            failed_in  = 1'b0;
         end else begin
            pos_in = pos_plus1[ELEM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= ELEM_W'(1);
         depth_ff     <= '0;
         next_ff      <= NEXT_W'(1);
         pos_ff       <= '0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         depth_ff     <= depth_in;
         next_ff      <= next_in;
         pos_ff       <= pos_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         element_ff <= req_element;
      end
      if (cmd.finish) begin
         rsp_verdict_ff <= verdict_in;
         rsp_last_ff    <= order_closed;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[depth_ff[ADDR_W-1:0]] <= next_ff[ELEM_W-1:0];
      end
      if (cmd.fetch) begin
         top_ff <= stack_mem[rd_addr];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

### src/stack_permutation_checker_core.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_element
// rsp       out        rsp_valid/rsp_ready    rsp_verdict, rsp_last
// csr       in         csr_wr_en              csr_wr_data (element_count)
//
// Each beat steps through the states idle, fetch, decide, push and finish;
// push, skipped when no run is pushed, puts one element on the stack per cycle.
// The next beat is taken while the previous result still waits on rsp.
// Reset clears the order state and sets element_count to 1; the stack memory
// needs no clearing pass and the block accepts a beat right after reset.
// A stalled rsp holds the block in its final step until the result is taken.
module stack_permutation_checker_core #(
   parameter int MAX_ELEMENTS = spc_pkg::MAX_ELEMENTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [spc_pkg::ELEM_W-1:0]    csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [spc_pkg::ELEM_W-1:0]    req_element,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [spc_pkg::VERDICT_W-1:0] rsp_verdict,
   output logic                          rsp_last
);

   spc_pkg::cmd_type    cmd;
   spc_pkg::status_type status;

   spc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   spc_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_element (req_element),
      .cmd         (cmd),
      .status      (status),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_verdict (rsp_verdict),
      .rsp_last    (rsp_last)
   );

endmodule

### src/spc_checker.sv
`include "stack_permutation_checker_core_assert.svh"

module spc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [spc_pkg::VERDICT_W-1:0] rsp_verdict,
   input logic                          rsp_last
);

   `SPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_verdict) && $stable(rsp_last), "rsp beat changed while stalled")

   // A verdict is given exactly on the beat that closes an order.
   `SPC_ASSERT_SAME(a_verdict_last, clock, reset, rsp_valid, (rsp_verdict != spc_pkg::VERDICT_PENDING) == rsp_last, "verdict and last disagree")

   `SPC_ASSERT_SAME(a_verdict_code, clock, reset, rsp_valid, rsp_verdict == spc_pkg::VERDICT_PENDING || rsp_verdict == spc_pkg::VERDICT_ACCEPT || rsp_verdict == spc_pkg::VERDICT_REJECT, "unknown verdict code")

   // Items are worked one at a time, so an accepted beat closes the input.
   `SPC_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "input reopened right after a beat")

endmodule

bind stack_permutation_checker_core spc_checker u_spc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_verdict (rsp_verdict),
   .rsp_last    (rsp_last)
);
